>>> sv/resp_array_request_parser_macros.svh
// assertion macros shared by the checker of the array request parser
`ifndef RESP_ARRAY_REQUEST_PARSER_MACROS_SVH
`define RESP_ARRAY_REQUEST_PARSER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define RARP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rarp check failed");

// next-cycle implication, checked while out of reset
`define RARP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rarp check failed");

`endif

>>> sv/rarp_pkg.sv
// types and constants of the array request parser
package rarp_pkg;

	localparam int LEN_BITS = 32;
	localparam int PROD_BITS = LEN_BITS + 4;

	typedef logic [LEN_BITS-1:0] len_t;
	typedef logic [2:0] event_t;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_ARR_LEN = 3'd1,
		PH_ARR     = 3'd2,
		PH_STR_LEN = 3'd3,
		PH_STR     = 3'd4
	} phase_t;

	localparam event_t EV_CONSUMED = 3'd0;
	localparam event_t EV_DATA     = 3'd1;
	localparam event_t EV_ELEM_END = 3'd2;
	localparam event_t EV_COMPLETE = 3'd3;
	localparam event_t EV_ERROR    = 3'd4;

	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

>>> sv/resp_array_request_parser.sv
// array request parser: one received byte in, one parse event out
//
// Input channel: rx_byte with in_valid / in_ready, one byte per transfer.
// Output channel: event_res, byte_value, elements_left with out_valid /
// out_ready, exactly one result per input byte, in order.
// A byte is registered on its transfer, and the parse step (count and length
// accumulation, overflow check, element countdown) runs between that register
// and the result register, so a result is offered once it has passed the input
// register and then the result register. One byte per cycle is sustained while
// out_ready holds; the phase and counter registers update with each advance.
// While the receiver stalls, a held result keeps its register and the input
// register still takes one more byte; after that in_ready drops until
// out_ready returns.
// Reset empties both registers and puts the parser at the start of a request
// with all counts zero. After a complete request or an error the parser is
// back at the start and expects '*'.
module resp_array_request_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output rarp_pkg::event_t    event_res,
	output logic [7:0]          byte_value,
	output logic [31:0]         elements_left
);
	import rarp_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       adv;

	phase_t phase_q, phase_n;
	len_t   arr_q, arr_n;
	len_t   str_q, str_n;
	logic   cr_q, cr_n;

	event_t     ev;
	logic [7:0] val;
	logic       is_digit;
	logic [3:0] digit;
	len_t       num_acc;
	logic [PROD_BITS-1:0] num_prod;
	logic       num_ovf;
	len_t       arr_dec;

	event_t      event_q;
	logic [7:0]  byte_q;
	logic [31:0] left_q;
	logic        out_valid_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	assign is_digit = (rx_byte_s1 >= CH_ZERO) && (rx_byte_s1 <= CH_NINE);
	assign digit    = 4'(rx_byte_s1 - CH_ZERO);
	assign num_acc  = (phase_q == PH_STR_LEN) ? str_q : arr_q;
	// acc * 10 + digit, overflow when any bit above the count width is set
	assign num_prod = ({4'd0, num_acc} << 3) + ({4'd0, num_acc} << 1)
		+ PROD_BITS'(digit);
	assign num_ovf  = |num_prod[PROD_BITS-1:LEN_BITS];
	assign arr_dec  = arr_q - len_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			arr_q   <= '0;
			str_q   <= '0;
			cr_q    <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_n;
			arr_q   <= arr_n;
			str_q   <= str_n;
			cr_q    <= cr_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		arr_n   = arr_q;
		str_n   = str_q;
		cr_n    = cr_q;
		ev      = EV_CONSUMED;
		val     = 8'd0;
		case (phase_q)
			PH_START: begin
				if (rx_byte_s1 == CH_STAR) begin
					phase_n = PH_ARR_LEN;
					arr_n   = '0;
					str_n   = '0;
					cr_n    = 1'b0;
				end else begin
					ev = EV_ERROR;
				end
			end
			PH_ARR_LEN: begin
				if (is_digit) begin
					if (num_ovf) begin
						ev = EV_ERROR;
					end else begin
						arr_n = num_prod[LEN_BITS-1:0];
					end
				end else if (rx_byte_s1 == CH_CR) begin
					cr_n = 1'b1;
				end else if (rx_byte_s1 == CH_LF && cr_q) begin
					cr_n = 1'b0;
					if (arr_q == '0) begin
						ev = EV_COMPLETE;
					end else begin
						phase_n = PH_ARR;
					end
				end else begin
					ev = EV_ERROR;
				end
			end
			PH_ARR: begin
				if (rx_byte_s1 == CH_DOLLAR) begin
					str_n   = '0;
					cr_n    = 1'b0;
					phase_n = PH_STR_LEN;
				end else begin
					ev = EV_ERROR;
				end
			end
			PH_STR_LEN: begin
				if (is_digit) begin
					if (num_ovf) begin
						ev = EV_ERROR;
					end else begin
						str_n = num_prod[LEN_BITS-1:0];
					end
				end else if (rx_byte_s1 == CH_CR) begin
					cr_n = 1'b1;
				end else if (rx_byte_s1 == CH_LF && cr_q) begin
					cr_n    = 1'b0;
					phase_n = PH_STR;
				end else begin
					ev = EV_ERROR;
				end
			end
			PH_STR: begin
				if (str_q != '0) begin
					str_n = str_q - len_t'(1);
					ev    = EV_DATA;
					val   = rx_byte_s1;
				end else if (rx_byte_s1 == CH_CR) begin
					cr_n = 1'b1;
				end else if (rx_byte_s1 == CH_LF && cr_q) begin
					cr_n  = 1'b0;
					arr_n = arr_dec;
					if (arr_dec == '0) begin
						ev = EV_COMPLETE;
					end else begin
						ev      = EV_ELEM_END;
						phase_n = PH_ARR;
					end
				end else begin
					ev = EV_ERROR;
				end
			end
			default: begin
				phase_n = PH_START;
				arr_n   = '0;
				str_n   = '0;
				cr_n    = 1'b0;
			end
		endcase
		// a finished or failed request leaves a clean start
		if (ev == EV_ERROR || ev == EV_COMPLETE) begin
			phase_n = PH_START;
			arr_n   = '0;
			str_n   = '0;
			cr_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			event_q <= ev;
			byte_q  <= val;
			left_q  <= 32'(arr_n);
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = event_q;
	assign byte_value    = byte_q;
	assign elements_left = left_q;

endmodule

>>> sv/rarp_checker.sv
// port-level checks of the array request parser and their bind
`include "resp_array_request_parser_macros.svh"

module rarp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [7:0]          rx_byte,
	input logic                out_valid,
	input logic                out_ready,
	input rarp_pkg::event_t    event_res,
	input logic [7:0]          byte_value,
	input logic [31:0]         elements_left
);
	import rarp_pkg::*;

	`RARP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(byte_value) && $stable(elements_left))
	`RARP_ASSERT_NOW(a_byte_only_data, out_valid && event_res != EV_DATA, byte_value == 8'd0)
	`RARP_ASSERT_NOW(a_end_clears, out_valid && (event_res == EV_ERROR || event_res == EV_COMPLETE), elements_left == 32'd0)
	`RARP_ASSERT_NOW(a_elem_end_left, out_valid && event_res == EV_ELEM_END, elements_left != 32'd0)
	`RARP_ASSERT_NOW(a_event_code, out_valid, event_res == EV_CONSUMED || event_res == EV_DATA || event_res == EV_ELEM_END || event_res == EV_COMPLETE || event_res == EV_ERROR)

endmodule

bind resp_array_request_parser rarp_checker u_rarp_checker (.*);

>>> sim/tb_resp_array_request_parser.sv
// self-checking testbench of the array request parser: directed and random byte streams
module tb_resp_array_request_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import rarp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		event_t     ev;
		logic [7:0] val;
		logic [31:0] left;
	} parse_result_t;

	typedef enum logic [1:0] {
		NUM_MORE,
		NUM_DONE,
		NUM_BAD
	} num_step_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	event_t      event_res;
	logic [7:0]  byte_value;
	logic [31:0] elements_left;

	int send_idle = 0;
	int recv_stall = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int tx_total = 0;

	logic [7:0]    tx_bytes[$];
	parse_result_t pending_results[$];

	phase_t ph = PH_START;
	len_t   arr_cnt = '0;
	len_t   str_cnt = '0;
	logic   cr_seen = 1'b0;

	resp_array_request_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.byte_value   (byte_value),
		.elements_left(elements_left)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_parse();
		ph = PH_START;
		arr_cnt = '0;
		str_cnt = '0;
		cr_seen = 1'b0;
	endfunction

	function automatic num_step_t number_step(inout len_t acc, input logic [7:0] b);
		logic [63:0] digit;
		logic [63:0] top;
		top = (64'd1 << LEN_BITS) - 64'd1;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			digit = 64'(b - CH_ZERO);
			if (64'(acc) > (top - digit) / 64'd10)
				return NUM_BAD;
			acc = len_t'(64'(acc) * 64'd10 + digit);
			return NUM_MORE;
		end
		if (b == CH_CR) begin
			cr_seen = 1'b1;
			return NUM_MORE;
		end
		if (b == CH_LF && cr_seen) begin
			cr_seen = 1'b0;
			return NUM_DONE;
		end
		return NUM_BAD;
	endfunction

	function automatic parse_result_t parse_byte(input logic [7:0] b);
		parse_result_t r;
		num_step_t     s;
		r.ev = EV_CONSUMED;
		r.val = 8'h00;
		case (ph)
			PH_START: begin
				if (b == CH_STAR) begin
					clear_parse();
					ph = PH_ARR_LEN;
				end else begin
					r.ev = EV_ERROR;
				end
			end
			PH_ARR_LEN: begin
				s = number_step(arr_cnt, b);
				if (s == NUM_BAD)
					r.ev = EV_ERROR;
				else if (s == NUM_DONE) begin
					if (arr_cnt == '0)
						r.ev = EV_COMPLETE;
					else
						ph = PH_ARR;
				end
			end
			PH_ARR: begin
				if (b == CH_DOLLAR) begin
					str_cnt = '0;
					cr_seen = 1'b0;
					ph = PH_STR_LEN;
				end else begin
					r.ev = EV_ERROR;
				end
			end
			PH_STR_LEN: begin
				s = number_step(str_cnt, b);
				if (s == NUM_BAD)
					r.ev = EV_ERROR;
				else if (s == NUM_DONE)
					ph = PH_STR;
			end
			PH_STR: begin
				if (str_cnt != '0) begin
					str_cnt = str_cnt - 1'b1;
					r.ev = EV_DATA;
					r.val = b;
				end else if (b == CH_CR) begin
					cr_seen = 1'b1;
				end else if (b == CH_LF && cr_seen) begin
					cr_seen = 1'b0;
					arr_cnt = arr_cnt - 1'b1;
					if (arr_cnt == '0) begin
						r.ev = EV_COMPLETE;
					end else begin
						r.ev = EV_ELEM_END;
						ph = PH_ARR;
					end
				end else begin
					r.ev = EV_ERROR;
				end
			end
			default: clear_parse();
		endcase
		if (r.ev == EV_ERROR || r.ev == EV_COMPLETE)
			clear_parse();
		r.left = 32'(arr_cnt);
		return r;
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with none pending: event_res %0d", event_res);
				mismatches++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (event_res !== want.ev) begin
					$error("event_res expected %0d actual %0d", want.ev, event_res);
					mismatches++;
				end
				if (byte_value !== want.val) begin
					$error("byte_value expected %0d actual %0d", want.val, byte_value);
					mismatches++;
				end
				if (elements_left !== want.left) begin
					$error("elements_left expected %0d actual %0d", want.left, elements_left);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("resp_array_request_parser verification failed");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		pending_results.insert(pending_results.size(), parse_byte(b));
		tx_total++;
	endtask

	task automatic flush_tx();
		for (int i = 0; i < tx_bytes.size(); i++)
			send_byte(tx_bytes[i]);
		tx_bytes.delete();
	endtask

	function automatic void add_byte(input logic [7:0] b);
		tx_bytes.insert(tx_bytes.size(), b);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic void add_crlf();
		add_byte(CH_CR);
		add_byte(CH_LF);
	endfunction

	function automatic void add_digits(input int count);
		for (int i = 0; i < count; i++)
			add_byte(CH_ZERO + 8'($urandom_range(9)));
	endfunction

	// decimal with optional empty form, leading zero, stray cr and extra cr
	function automatic void add_number(input int value);
		string s;
		int    style;
		s = $sformatf("%0d", value);
		style = $urandom_range(9);
		if (style == 0 && value == 0) begin
		end else if (style == 1) begin
			add_text({"0", s});
		end else if (style == 2 && s.len() > 1) begin
			add_byte(s[0]);
			add_byte(CH_CR);
			add_text(s.substr(1, s.len() - 1));
		end else begin
			add_text(s);
		end
		if (style == 3)
			add_byte(CH_CR);
		add_crlf();
	endfunction

	function automatic void add_request();
		int count;
		int len;
		count = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
		add_text("*");
		add_number(count);
		for (int e = 0; e < count; e++) begin
			len = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 5);
			add_text("$");
			add_number(len);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 15)
					add_byte($urandom_range(1) ? CH_CR : CH_LF);
				else
					add_byte(8'($urandom_range(255)));
			end
			add_crlf();
		end
	endfunction

	task automatic test_unexpected_bytes();
		add_byte(8'h00);
		add_text("*");
		add_byte(CH_LF);
		flush_tx();
	endtask

	task automatic test_raw_payload();
		add_text("*2");
		add_crlf();
		add_text("$3");
		add_crlf();
		add_crlf();
		add_byte(8'hff);
		add_crlf();
		add_text("$0");
		add_crlf();
		add_crlf();
		flush_tx();
	endtask

	task automatic test_count_overflow();
		add_text("*4294967296");
		flush_tx();
	endtask

	task automatic test_random_requests(input int items, input int idle_pct,
			input int stall_pct);
		int start;
		int kind;
		int idx;
		send_idle = idle_pct;
		recv_stall = stall_pct;
		start = tx_total;
		while (tx_total - start < items) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				add_request();
			end else if (kind < 88) begin
				add_request();
				idx = $urandom_range(tx_bytes.size() - 1);
				tx_bytes[idx] = 8'($urandom_range(255));
			end else if (kind < 94) begin
				// huge count and length, near and past the counter limit
				add_text("*");
				if ($urandom_range(3) == 0)
					add_text("4294967295");
				else
					add_digits($urandom_range(9, 11));
				add_crlf();
				add_text("$");
				add_digits($urandom_range(9, 11));
				add_crlf();
				add_digits(2);
			end else begin
				for (int i = $urandom_range(1, 6); i > 0; i--)
					add_byte(8'($urandom_range(255)));
			end
			flush_tx();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unexpected_bytes();
		test_raw_payload();
		test_count_overflow();
		test_random_requests(175, 0, 0);
		test_random_requests(175, 64, 0);
		test_random_requests(175, 0, 64);
		test_random_requests(175, 23, 23);
		in_valid <= 1'b0;
		recv_stall = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("resp_array_request_parser verification clean");
		else
			$display("resp_array_request_parser verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/rarp_pkg.sv
sv/resp_array_request_parser.sv
sv/rarp_checker.sv
sim/tb_resp_array_request_parser.sv
